FILE: rtl/gpio_port_edge_interrupt_macros.svh
// Assertion macros for the GPIO port with edge interrupts.
// Used by the top level; the macros expect clk and rst_n in scope.
`ifndef GPIO_PORT_EDGE_INTERRUPT_MACROS_SVH
`define GPIO_PORT_EDGE_INTERRUPT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GPE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gpio port assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define GPE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gpio port assertion failed");

`endif

FILE: rtl/gpe_pkg.sv
// Shared types and codes for the GPIO port with edge interrupts.
// No dependencies; imported by the lane, merge and top-level modules.
package gpe_pkg;

  localparam int unsigned PIN_MAX = 16;

  localparam logic [1:0] MODE_READ   = 2'd0;
  localparam logic [1:0] MODE_WRITE  = 2'd1;
  localparam logic [1:0] MODE_SAMPLE = 2'd2;

  localparam logic [3:0] REG_DIR     = 4'd0;
  localparam logic [3:0] REG_OTYPE   = 4'd1;
  localparam logic [3:0] REG_SPEED   = 4'd2;
  localparam logic [3:0] REG_PULL    = 4'd3;
  localparam logic [3:0] REG_IN      = 4'd4;
  localparam logic [3:0] REG_OUT     = 4'd5;
  localparam logic [3:0] REG_MASK    = 4'd6;
  localparam logic [3:0] REG_RISE    = 4'd7;
  localparam logic [3:0] REG_FALL    = 4'd8;
  localparam logic [3:0] REG_PENDING = 4'd9;
  localparam logic [3:0] REG_LEVEL   = 4'd10;

  localparam logic [1:0] DIR_OUTPUT = 2'b01;

  // What one lane sees of an accepted item.
  typedef struct packed {
    logic       acc;
    logic [1:0] mode;
    logic [3:0] reg_index;
    logic [1:0] wfield;
    logic       wbit;
    logic       level;
  } lane_cmd_t;

  // One pin's state after the item has been applied.
  typedef struct packed {
    logic [1:0] dir;
    logic       otype;
    logic [1:0] speed;
    logic [1:0] pull;
    logic       latch;
    logic       sampled;
    logic       mask;
    logic       rise;
    logic       fall;
    logic       pending;
  } lane_state_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_request;
    logic [15:0] pin_drive;
    logic [15:0] pin_drive_enable;
  } result_t;

endpackage

FILE: rtl/gpe_lane.sv
// One pin of the GPIO port: its settings, latch, sampled level and pending bit.
// Depends on gpe_pkg.
module gpe_lane
  import gpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  lane_cmd_t   cmd,
  output lane_state_t st_nxt
);

  lane_state_t st_r;

  always_comb begin
    logic edge_hit;
    edge_hit = 1'b0;
    st_nxt   = st_r;
    if (cmd.acc && cmd.mode == MODE_WRITE) begin
      unique case (cmd.reg_index)
        REG_DIR:     st_nxt.dir     = cmd.wfield;
        REG_OTYPE:   st_nxt.otype   = cmd.wbit;
        REG_SPEED:   st_nxt.speed   = cmd.wfield;
        REG_PULL:    st_nxt.pull    = cmd.wfield;
        REG_OUT:     st_nxt.latch   = cmd.wbit;
        REG_MASK:    st_nxt.mask    = cmd.wbit;
        REG_RISE:    st_nxt.rise    = cmd.wbit;
        REG_FALL:    st_nxt.fall    = cmd.wbit;
        REG_PENDING: st_nxt.pending = st_r.pending & ~cmd.wbit;
        default:     st_nxt         = st_r;
      endcase
    end else if (cmd.acc && cmd.mode == MODE_SAMPLE) begin
      // Edge against the previous sample, qualified by select and mask.
      edge_hit = ((cmd.level & ~st_r.sampled & st_r.rise) |
                  (~cmd.level & st_r.sampled & st_r.fall)) & st_r.mask;
      st_nxt.pending = st_r.pending | edge_hit;
      st_nxt.sampled = cmd.level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

FILE: rtl/gpe_merge.sv
// Merging stage: gathers all pin lanes into register words and pin outputs.
// Depends on gpe_pkg.
module gpe_merge
  import gpe_pkg::*;
#(
  parameter int unsigned PIN_COUNT = 16
) (
  input  lane_state_t lanes [PIN_COUNT],
  input  logic [1:0]  mode,
  input  logic [3:0]  reg_index,
  output result_t     res
);

  logic [31:0] dir_v, speed_v, pull_v;
  logic [15:0] otype_v, latch_v, sampled_v, mask_v, rise_v, fall_v, pend_v;
  logic [15:0] level_v, en_v;
  logic [31:0] rd;

  always_comb begin
    dir_v     = '0;
    speed_v   = '0;
    pull_v    = '0;
    otype_v   = '0;
    latch_v   = '0;
    sampled_v = '0;
    mask_v    = '0;
    rise_v    = '0;
    fall_v    = '0;
    pend_v    = '0;
    level_v   = '0;
    en_v      = '0;
    for (int p = 0; p < PIN_COUNT; p++) begin
      dir_v[2*p +: 2]   = lanes[p].dir;
      speed_v[2*p +: 2] = lanes[p].speed;
      pull_v[2*p +: 2]  = lanes[p].pull;
      otype_v[p]        = lanes[p].otype;
      latch_v[p]        = lanes[p].latch;
      sampled_v[p]      = lanes[p].sampled;
      mask_v[p]         = lanes[p].mask;
      rise_v[p]         = lanes[p].rise;
      fall_v[p]         = lanes[p].fall;
      pend_v[p]         = lanes[p].pending;
      level_v[p]        = (lanes[p].dir != 2'b00) ? lanes[p].latch : lanes[p].sampled;
      en_v[p]           = (lanes[p].dir == DIR_OUTPUT);
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_DIR:     rd = dir_v;
      REG_OTYPE:   rd = {16'd0, otype_v};
      REG_SPEED:   rd = speed_v;
      REG_PULL:    rd = pull_v;
      REG_IN:      rd = {16'd0, sampled_v};
      REG_OUT:     rd = {16'd0, latch_v};
      REG_MASK:    rd = {16'd0, mask_v};
      REG_RISE:    rd = {16'd0, rise_v};
      REG_FALL:    rd = {16'd0, fall_v};
      REG_PENDING: rd = {16'd0, pend_v};
      REG_LEVEL:   rd = {16'd0, level_v};
      default:     rd = '0;
    endcase
  end

  assign res.read_data        = (mode == MODE_READ) ? rd : 32'd0;
  assign res.irq_request      = |pend_v;
  assign res.pin_drive        = latch_v & en_v;
  assign res.pin_drive_enable = en_v;

endmodule

FILE: rtl/gpio_port_edge_interrupt.sv
// Top level of the GPIO port with edge interrupts.
// Depends on gpe_pkg, gpe_lane, gpe_merge and gpio_port_edge_interrupt_macros.svh.
//
// Usage:
// Every input item is a bus read, a bus write or one sample of the pin
// levels, selected by in_mode. It is taken when in_valid and in_ready are
// both high. Every item gives exactly one result item on the out_ channel,
// which reports read data (zero unless the item was a read), the interrupt
// request and the pin drive and drive-enable values after the item.
// One lane per pin holds that pin's settings, latch, sampled level and
// pending bit and applies the item in the cycle it is accepted; a merging
// stage packs the lanes into register words, and its output is registered.
// The result is therefore registered after the item is accepted, and the
// block sustains one item per clock cycle unless the output buffer fills,
// as set by the single lane register stage and the output register.
// A two-entry output buffer (output register plus skid register) lets one
// more item be accepted while a result waits; in_ready falls only when
// both entries are full, and rises again once the receiver takes one.
// Synchronous reset clears every pin setting, latch, sample, mask, select
// and pending bit, and empties the output buffer.
module gpio_port_edge_interrupt
  import gpe_pkg::*;
#(
  parameter int unsigned PIN_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_reg_index,
  input  logic [31:0] in_write_data,
  input  logic [15:0] in_pin_levels,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_irq_request,
  output logic [15:0] out_pin_drive,
  output logic [15:0] out_pin_drive_enable
);

  `include "gpio_port_edge_interrupt_macros.svh"

  logic        accept;
  logic        pop;
  lane_state_t lane_st [PIN_COUNT];
  result_t     res;

  logic        out_valid_r, out_valid_nxt;
  logic        skid_valid_r, skid_valid_nxt;
  result_t     out_data_r, out_data_nxt;
  result_t     skid_data_r, skid_data_nxt;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign pop      = out_valid_r && out_ready;

  // One lane per pin; each sees its own slice of the write data and levels.
  for (genvar p = 0; p < PIN_COUNT; p++) begin : g_lane
    lane_cmd_t cmd;
    assign cmd.acc       = accept;
    assign cmd.mode      = in_mode;
    assign cmd.reg_index = in_reg_index;
    assign cmd.wfield    = in_write_data[2*p +: 2];
    assign cmd.wbit      = in_write_data[p];
    assign cmd.level     = in_pin_levels[p];

    gpe_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .st_nxt (lane_st[p])
    );
  end

  gpe_merge #(
    .PIN_COUNT (PIN_COUNT)
  ) u_merge (
    .lanes     (lane_st),
    .mode      (in_mode),
    .reg_index (in_reg_index),
    .res       (res)
  );

  // Output buffer: a new result goes to the output register when it is
  // free or being drained, otherwise it parks in the skid register.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (pop) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || pop) begin
        out_data_nxt  = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_read_data        = out_data_r.read_data;
  assign out_irq_request      = out_data_r.irq_request;
  assign out_pin_drive        = out_data_r.pin_drive;
  assign out_pin_drive_enable = out_data_r.pin_drive_enable;

  // The skid register is only ever filled behind a full output register.
  `GPE_ASSERT_IMP(a_skid_behind_out, skid_valid_r, out_valid_r)
  // An item accepted while the output is stalled lands in the skid register.
  `GPE_ASSERT_NXT(a_stall_to_skid, accept && out_valid_r && !out_ready, skid_valid_r)
  // Pins are only driven where their drive is enabled.
  `GPE_ASSERT_IMP(a_drive_enabled, out_valid_r,
                  (out_pin_drive & ~out_pin_drive_enable) == 16'd0)

endmodule
